/* rtl/rvdec_pkg.sv */
package rvdec_pkg;

   localparam logic [6:0] OP_R     = 7'b0110011;
   localparam logic [6:0] OP_S     = 7'b0100011;
   localparam logic [6:0] OP_B     = 7'b1100011;
   localparam logic [6:0] OP_LUI   = 7'b0110111;
   localparam logic [6:0] OP_AUIPC = 7'b0010111;
   localparam logic [6:0] OP_JAL   = 7'b1101111;
   localparam logic [6:0] OP_JALR  = 7'b1100111;
   localparam logic [6:0] OP_LOAD  = 7'b0000011;
   localparam logic [6:0] OP_IALU  = 7'b0010011;
   localparam logic [6:0] OP_FENCE = 7'b0001111;
   localparam logic [6:0] OP_SYS   = 7'b1110011;
   localparam logic [6:0] F7_ALT   = 7'b0100000;
   localparam logic [6:0] F7_BASE  = 7'b0000000;

   typedef enum logic [2:0] {
      FMT_R = 3'd0,
      FMT_I = 3'd1,
      FMT_S = 3'd2,
      FMT_B = 3'd3,
      FMT_U = 3'd4,
      FMT_J = 3'd5
   } format_type;

   typedef enum logic [5:0] {
      MN_ADD    = 6'd0,  MN_SUB    = 6'd1,  MN_SLL    = 6'd2,  MN_SLT    = 6'd3,
      MN_SLTU   = 6'd4,  MN_XOR    = 6'd5,  MN_SRL    = 6'd6,  MN_SRA    = 6'd7,
      MN_OR     = 6'd8,  MN_AND    = 6'd9,
      MN_LB     = 6'd10, MN_LH     = 6'd11, MN_LW     = 6'd12, MN_LBU    = 6'd13,
      MN_LHU    = 6'd14,
      MN_SB     = 6'd15, MN_SH     = 6'd16, MN_SW     = 6'd17,
      MN_BEQ    = 6'd18, MN_BNE    = 6'd19, MN_BLT    = 6'd20, MN_BGE    = 6'd21,
      MN_BLTU   = 6'd22, MN_BGEU   = 6'd23,
      MN_LUI    = 6'd24, MN_AUIPC  = 6'd25, MN_JAL    = 6'd26, MN_JALR   = 6'd27,
      MN_ADDI   = 6'd28, MN_SLTI   = 6'd29, MN_SLTIU  = 6'd30, MN_XORI   = 6'd31,
      MN_ORI    = 6'd32, MN_ANDI   = 6'd33,
      MN_SLLI   = 6'd34, MN_SRLI   = 6'd35, MN_SRAI   = 6'd36,
      MN_FENCE  = 6'd37, MN_FENCEI = 6'd38, MN_ECALL  = 6'd39, MN_EBREAK = 6'd40,
      MN_CSRRW  = 6'd41, MN_CSRRS  = 6'd42, MN_CSRRC  = 6'd43,
      MN_CSRRWI = 6'd44, MN_CSRRSI = 6'd45, MN_CSRRCI = 6'd46
   } mnemonic_type;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] instr_addr;
   } req_type;

   typedef struct packed {
      logic               valid_res;
      format_type         format;
      mnemonic_type       mnemonic;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic signed [31:0] immediate;
      logic [31:0]        target;
   } rsp_type;

endpackage

/* rtl/rv32i_instruction_decoder.sv */
// RV32I instruction decoder. One item (instruction word and its address) may be
// started every cycle; busy never rises. The result appears on rsp_data with
// rsp_strobe high for one cycle, after the item has passed an input register, a
// decode register and an output register that follows the branch/jump target
// adder. Unknown encodings give an all-zero result.
module rv32i_instruction_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rvdec_pkg::req_type req_data,
   output logic              rsp_strobe,
   output rvdec_pkg::rsp_type rsp_data
);

   // stage 1: input register
   logic               s1_valid_ff;
   rvdec_pkg::req_type s1_data_ff;

   // stage 2: decoded fields
   logic                    s2_valid_ff, s2_valid_in;
   logic                    s2_ok_ff, s2_ok_in;
   rvdec_pkg::format_type   s2_fmt_ff, s2_fmt_in;
   rvdec_pkg::mnemonic_type s2_mn_ff, s2_mn_in;
   logic [4:0]              s2_rd_ff, s2_rd_in;
   logic [4:0]              s2_rs1_ff, s2_rs1_in;
   logic [4:0]              s2_rs2_ff, s2_rs2_in;
   logic [31:0]             s2_imm_ff, s2_imm_in;
   logic                    s2_tgt_ff, s2_tgt_in;
   logic [31:0]             s2_addr_ff;

   // stage 3: output register
   logic               s3_valid_ff;
   rvdec_pkg::rsp_type s3_data_ff, s3_data_in;

   logic [31:0] w;
   logic [6:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rd, rs1, rs2;
   logic [31:0] imm_i;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_data_ff <= req_data;
      s2_ok_ff   <= s2_ok_in;
      s2_fmt_ff  <= s2_fmt_in;
      s2_mn_ff   <= s2_mn_in;
      s2_rd_ff   <= s2_rd_in;
      s2_rs1_ff  <= s2_rs1_in;
      s2_rs2_ff  <= s2_rs2_in;
      s2_imm_ff  <= s2_imm_in;
      s2_tgt_ff  <= s2_tgt_in;
      s2_addr_ff <= s1_data_ff.instr_addr;
      s3_data_ff <= s3_data_in;
   end

   assign s2_valid_in = s1_valid_ff;
   assign w     = s1_data_ff.instr_word;
   assign op    = w[6:0];
   assign rd    = w[11:7];
   assign f3    = w[14:12];
   assign rs1   = w[19:15];
   assign rs2   = w[24:20];
   assign f7    = w[31:25];
   assign imm_i = {{20{w[31]}}, w[31:20]};

   always_comb begin
      s2_ok_in  = 1'b1;
      s2_fmt_in = rvdec_pkg::FMT_R;
      s2_mn_in  = rvdec_pkg::MN_ADD;
      s2_rd_in  = 5'd0;
      s2_rs1_in = 5'd0;
      s2_rs2_in = 5'd0;
      s2_imm_in = 32'd0;
      s2_tgt_in = 1'b0;
      unique case (op)
         rvdec_pkg::OP_R: begin
            s2_fmt_in = rvdec_pkg::FMT_R;
            s2_rd_in  = rd;
            s2_rs1_in = rs1;
            s2_rs2_in = rs2;
            if (f7 == rvdec_pkg::F7_BASE) begin
               unique case (f3)
                  3'd0: s2_mn_in = rvdec_pkg::MN_ADD;
                  3'd1: s2_mn_in = rvdec_pkg::MN_SLL;
                  3'd2: s2_mn_in = rvdec_pkg::MN_SLT;
                  3'd3: s2_mn_in = rvdec_pkg::MN_SLTU;
                  3'd4: s2_mn_in = rvdec_pkg::MN_XOR;
                  3'd5: s2_mn_in = rvdec_pkg::MN_SRL;
                  3'd6: s2_mn_in = rvdec_pkg::MN_OR;
                  default: s2_mn_in = rvdec_pkg::MN_AND;
               endcase
            end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
               s2_mn_in = rvdec_pkg::MN_SUB;
            end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
               s2_mn_in = rvdec_pkg::MN_SRA;
            end else begin
               s2_ok_in = 1'b0;
            end
         end
         rvdec_pkg::OP_LOAD: begin
            s2_fmt_in = rvdec_pkg::FMT_I;
            s2_rd_in  = rd;
            s2_rs1_in = rs1;
            s2_imm_in = imm_i;
            unique case (f3)
               3'd0: s2_mn_in = rvdec_pkg::MN_LB;
               3'd1: s2_mn_in = rvdec_pkg::MN_LH;
               3'd2: s2_mn_in = rvdec_pkg::MN_LW;
               3'd4: s2_mn_in = rvdec_pkg::MN_LBU;
               3'd5: s2_mn_in = rvdec_pkg::MN_LHU;
               default: s2_ok_in = 1'b0;
            endcase
         end
         rvdec_pkg::OP_S: begin
            s2_fmt_in = rvdec_pkg::FMT_S;
            s2_rs1_in = rs1;
            s2_rs2_in = rs2;
            s2_imm_in = {{20{w[31]}}, w[31:25], w[11:7]};
            unique case (f3)
               3'd0: s2_mn_in = rvdec_pkg::MN_SB;
               3'd1: s2_mn_in = rvdec_pkg::MN_SH;
               3'd2: s2_mn_in = rvdec_pkg::MN_SW;
               default: s2_ok_in = 1'b0;
            endcase
         end
         rvdec_pkg::OP_B: begin
            s2_fmt_in = rvdec_pkg::FMT_B;
            s2_rs1_in = rs1;
            s2_rs2_in = rs2;
            s2_imm_in = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            s2_tgt_in = 1'b1;
            unique case (f3)
               3'd0: s2_mn_in = rvdec_pkg::MN_BEQ;
               3'd1: s2_mn_in = rvdec_pkg::MN_BNE;
               3'd4: s2_mn_in = rvdec_pkg::MN_BLT;
               3'd5: s2_mn_in = rvdec_pkg::MN_BGE;
               3'd6: s2_mn_in = rvdec_pkg::MN_BLTU;
               3'd7: s2_mn_in = rvdec_pkg::MN_BGEU;
               default: s2_ok_in = 1'b0;
            endcase
         end
         rvdec_pkg::OP_LUI: begin
            s2_fmt_in = rvdec_pkg::FMT_U;
            s2_rd_in  = rd;
            s2_imm_in = {{12{w[31]}}, w[31:12]};
            s2_mn_in  = rvdec_pkg::MN_LUI;
         end
         rvdec_pkg::OP_AUIPC: begin
            s2_fmt_in = rvdec_pkg::FMT_U;
            s2_rd_in  = rd;
            s2_imm_in = {{12{w[31]}}, w[31:12]};
            s2_mn_in  = rvdec_pkg::MN_AUIPC;
         end
         rvdec_pkg::OP_JAL: begin
            s2_fmt_in = rvdec_pkg::FMT_J;
            s2_rd_in  = rd;
            s2_mn_in  = rvdec_pkg::MN_JAL;
            s2_imm_in = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            s2_tgt_in = 1'b1;
         end
         rvdec_pkg::OP_JALR: begin
            s2_fmt_in = rvdec_pkg::FMT_I;
            s2_rd_in  = rd;
            s2_rs1_in = rs1;
            s2_imm_in = imm_i;
            s2_mn_in  = rvdec_pkg::MN_JALR;
            s2_ok_in  = (f3 == 3'd0);
         end
         rvdec_pkg::OP_IALU: begin
            s2_fmt_in = rvdec_pkg::FMT_I;
            s2_rd_in  = rd;
            s2_rs1_in = rs1;
            s2_imm_in = imm_i;
            unique case (f3)
               3'd0: s2_mn_in = rvdec_pkg::MN_ADDI;
               3'd1: begin
                  s2_mn_in  = rvdec_pkg::MN_SLLI;
                  s2_imm_in = {27'd0, rs2};
                  s2_ok_in  = (f7 == rvdec_pkg::F7_BASE);
               end
               3'd2: s2_mn_in = rvdec_pkg::MN_SLTI;
               3'd3: s2_mn_in = rvdec_pkg::MN_SLTIU;
               3'd4: s2_mn_in = rvdec_pkg::MN_XORI;
               3'd5: begin
                  s2_imm_in = {27'd0, rs2};
                  if (f7 == rvdec_pkg::F7_ALT) begin
                     s2_mn_in = rvdec_pkg::MN_SRAI;
                  end else begin
                     s2_mn_in = rvdec_pkg::MN_SRLI;
                     s2_ok_in = (f7 == rvdec_pkg::F7_BASE);
                  end
               end
               3'd6: s2_mn_in = rvdec_pkg::MN_ORI;
               default: s2_mn_in = rvdec_pkg::MN_ANDI;
            endcase
         end
         rvdec_pkg::OP_FENCE: begin
            s2_fmt_in = rvdec_pkg::FMT_I;
            s2_rd_in  = rd;
            s2_rs1_in = rs1;
            s2_imm_in = {24'd0, w[27:20]};
            unique case (f3)
               3'd0: s2_mn_in = rvdec_pkg::MN_FENCE;
               3'd1: s2_mn_in = rvdec_pkg::MN_FENCEI;
               default: s2_ok_in = 1'b0;
            endcase
         end
         rvdec_pkg::OP_SYS: begin
            s2_fmt_in = rvdec_pkg::FMT_I;
            if (f3 == 3'd0) begin
               s2_imm_in = {20'd0, w[31:20]};
               s2_ok_in  = (rd == 5'd0) && (rs1 == 5'd0) && (w[31:21] == 11'd0);
               s2_mn_in  = w[20] ? rvdec_pkg::MN_EBREAK : rvdec_pkg::MN_ECALL;
            end else begin
               s2_rd_in  = rd;
               s2_rs1_in = rs1;
               s2_imm_in = {20'd0, w[31:20]};
               unique case (f3)
                  3'd1: s2_mn_in = rvdec_pkg::MN_CSRRW;
                  3'd2: s2_mn_in = rvdec_pkg::MN_CSRRS;
                  3'd3: s2_mn_in = rvdec_pkg::MN_CSRRC;
                  3'd5: s2_mn_in = rvdec_pkg::MN_CSRRWI;
                  3'd6: s2_mn_in = rvdec_pkg::MN_CSRRSI;
                  3'd7: s2_mn_in = rvdec_pkg::MN_CSRRCI;
                  default: s2_ok_in = 1'b0;
               endcase
            end
         end
         default: s2_ok_in = 1'b0;
      endcase
   end

   // stage 3: target add and clearing of unknown encodings
   always_comb begin
      s3_data_in.valid_res = s2_ok_ff;
      s3_data_in.format    = rvdec_pkg::FMT_R;
      s3_data_in.mnemonic  = rvdec_pkg::MN_ADD;
      s3_data_in.dest_reg  = 5'd0;
      s3_data_in.src1_reg  = 5'd0;
      s3_data_in.src2_reg  = 5'd0;
      s3_data_in.immediate = 32'sd0;
      s3_data_in.target    = 32'd0;
      if (s2_ok_ff) begin
         s3_data_in.format    = s2_fmt_ff;
         s3_data_in.mnemonic  = s2_mn_ff;
         s3_data_in.dest_reg  = s2_rd_ff;
         s3_data_in.src1_reg  = s2_rs1_ff;
         s3_data_in.src2_reg  = s2_rs2_ff;
         s3_data_in.immediate = $signed(s2_imm_ff);
         if (s2_tgt_ff) begin
            s3_data_in.target = s2_addr_ff + s2_imm_ff;
         end
      end
   end

   assign rsp_strobe = s3_valid_ff;
   assign rsp_data   = s3_data_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 3))
      else $error("result without a started item");

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.valid_res) |->
         (rsp_data.mnemonic == rvdec_pkg::MN_ADD && rsp_data.immediate == 32'sd0
          && rsp_data.target == 32'd0 && rsp_data.format == rvdec_pkg::FMT_R))
      else $error("unknown encoding left fields set");

   a_target_fmt: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.target != 32'd0) |->
         (rsp_data.format == rvdec_pkg::FMT_B || rsp_data.format == rvdec_pkg::FMT_J))
      else $error("target set outside branch or jal");
`endif

endmodule

/* verif/rv32i_instruction_decoder_tb.sv */
`timescale 1ns / 1ps

module rv32i_instruction_decoder_tb;

   typedef struct {
      rvdec_pkg::req_type req;
      bit                 drain;
   } instr_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   rvdec_pkg::req_type req_data = '0;
   logic               rsp_strobe;
   rvdec_pkg::rsp_type rsp_data;

   instr_entry_type    instr_queue[$];
   rvdec_pkg::rsp_type expected_decodes[$];
   instr_entry_type    issue_entry;
   rvdec_pkg::rsp_type want_rsp;
   int                 issued = 0;
   int                 decode_mismatches = 0;
   bit                 gap;

   rv32i_instruction_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rvdec_pkg::rsp_type decode_rv32i(rvdec_pkg::req_type r);
      logic [31:0]        w;
      logic [6:0]         opc;
      logic [6:0]         f7;
      logic [2:0]         f3;
      logic [4:0]         rd;
      logic [4:0]         rs1;
      logic [4:0]         rs2;
      logic [31:0]        imm_i;
      logic               ok;
      rvdec_pkg::rsp_type o;
      w     = r.instr_word;
      opc   = w[6:0];
      rd    = w[11:7];
      f3    = w[14:12];
      rs1   = w[19:15];
      rs2   = w[24:20];
      f7    = w[31:25];
      imm_i = {{20{w[31]}}, w[31:20]};
      o     = '0;
      ok    = 1'b1;
      case (opc)
         rvdec_pkg::OP_R: begin
            o.format   = rvdec_pkg::FMT_R;
            o.dest_reg = rd;
            o.src1_reg = rs1;
            o.src2_reg = rs2;
            if (f7 == rvdec_pkg::F7_BASE) begin
               case (f3)
                  3'd0: o.mnemonic = rvdec_pkg::MN_ADD;
                  3'd1: o.mnemonic = rvdec_pkg::MN_SLL;
                  3'd2: o.mnemonic = rvdec_pkg::MN_SLT;
                  3'd3: o.mnemonic = rvdec_pkg::MN_SLTU;
                  3'd4: o.mnemonic = rvdec_pkg::MN_XOR;
                  3'd5: o.mnemonic = rvdec_pkg::MN_SRL;
                  3'd6: o.mnemonic = rvdec_pkg::MN_OR;
                  default: o.mnemonic = rvdec_pkg::MN_AND;
               endcase
            end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
               o.mnemonic = rvdec_pkg::MN_SUB;
            end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
               o.mnemonic = rvdec_pkg::MN_SRA;
            end else begin
               ok = 1'b0;
            end
         end
         rvdec_pkg::OP_LOAD: begin
            o.format    = rvdec_pkg::FMT_I;
            o.dest_reg  = rd;
            o.src1_reg  = rs1;
            o.immediate = imm_i;
            case (f3)
               3'd0: o.mnemonic = rvdec_pkg::MN_LB;
               3'd1: o.mnemonic = rvdec_pkg::MN_LH;
               3'd2: o.mnemonic = rvdec_pkg::MN_LW;
               3'd4: o.mnemonic = rvdec_pkg::MN_LBU;
               3'd5: o.mnemonic = rvdec_pkg::MN_LHU;
               default: ok = 1'b0;
            endcase
         end
         rvdec_pkg::OP_S: begin
            o.format    = rvdec_pkg::FMT_S;
            o.src1_reg  = rs1;
            o.src2_reg  = rs2;
            o.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
            case (f3)
               3'd0: o.mnemonic = rvdec_pkg::MN_SB;
               3'd1: o.mnemonic = rvdec_pkg::MN_SH;
               3'd2: o.mnemonic = rvdec_pkg::MN_SW;
               default: ok = 1'b0;
            endcase
         end
         rvdec_pkg::OP_B: begin
            o.format    = rvdec_pkg::FMT_B;
            o.src1_reg  = rs1;
            o.src2_reg  = rs2;
            o.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            o.target    = r.instr_addr + o.immediate;
            case (f3)
               3'd0: o.mnemonic = rvdec_pkg::MN_BEQ;
               3'd1: o.mnemonic = rvdec_pkg::MN_BNE;
               3'd4: o.mnemonic = rvdec_pkg::MN_BLT;
               3'd5: o.mnemonic = rvdec_pkg::MN_BGE;
               3'd6: o.mnemonic = rvdec_pkg::MN_BLTU;
               3'd7: o.mnemonic = rvdec_pkg::MN_BGEU;
               default: ok = 1'b0;
            endcase
         end
         rvdec_pkg::OP_LUI, rvdec_pkg::OP_AUIPC: begin
            o.format    = rvdec_pkg::FMT_U;
            o.dest_reg  = rd;
            o.immediate = {{12{w[31]}}, w[31:12]};
            o.mnemonic  = (opc == rvdec_pkg::OP_LUI) ? rvdec_pkg::MN_LUI
                                                     : rvdec_pkg::MN_AUIPC;
         end
         rvdec_pkg::OP_JAL: begin
            o.format    = rvdec_pkg::FMT_J;
            o.dest_reg  = rd;
            o.mnemonic  = rvdec_pkg::MN_JAL;
            o.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            o.target    = r.instr_addr + o.immediate;
         end
         rvdec_pkg::OP_JALR: begin
            o.format    = rvdec_pkg::FMT_I;
            o.dest_reg  = rd;
            o.src1_reg  = rs1;
            o.immediate = imm_i;
            o.mnemonic  = rvdec_pkg::MN_JALR;
            ok          = (f3 == 3'd0);
         end
         rvdec_pkg::OP_IALU: begin
            o.format    = rvdec_pkg::FMT_I;
            o.dest_reg  = rd;
            o.src1_reg  = rs1;
            o.immediate = imm_i;
            case (f3)
               3'd0: o.mnemonic = rvdec_pkg::MN_ADDI;
               3'd2: o.mnemonic = rvdec_pkg::MN_SLTI;
               3'd3: o.mnemonic = rvdec_pkg::MN_SLTIU;
               3'd4: o.mnemonic = rvdec_pkg::MN_XORI;
               3'd6: o.mnemonic = rvdec_pkg::MN_ORI;
               3'd7: o.mnemonic = rvdec_pkg::MN_ANDI;
               3'd1: begin
                  o.mnemonic  = rvdec_pkg::MN_SLLI;
                  o.immediate = {27'd0, rs2};
                  ok          = (f7 == rvdec_pkg::F7_BASE);
               end
               default: begin
                  o.immediate = {27'd0, rs2};
                  if (f7 == rvdec_pkg::F7_ALT) begin
                     o.mnemonic = rvdec_pkg::MN_SRAI;
                  end else begin
                     o.mnemonic = rvdec_pkg::MN_SRLI;
                     ok         = (f7 == rvdec_pkg::F7_BASE);
                  end
               end
            endcase
         end
         rvdec_pkg::OP_FENCE: begin
            o.format    = rvdec_pkg::FMT_I;
            o.dest_reg  = rd;
            o.src1_reg  = rs1;
            o.immediate = {24'd0, w[27:20]};
            case (f3)
               3'd0: o.mnemonic = rvdec_pkg::MN_FENCE;
               3'd1: o.mnemonic = rvdec_pkg::MN_FENCEI;
               default: ok = 1'b0;
            endcase
         end
         rvdec_pkg::OP_SYS: begin
            o.format = rvdec_pkg::FMT_I;
            if (f3 == 3'd0) begin
               ok          = (rd == 5'd0 && rs1 == 5'd0 && w[31:21] == 11'd0);
               o.mnemonic  = w[20] ? rvdec_pkg::MN_EBREAK : rvdec_pkg::MN_ECALL;
               o.immediate = {31'd0, w[20]};
            end else begin
               o.dest_reg  = rd;
               o.src1_reg  = rs1;
               o.immediate = {20'd0, w[31:20]};
               case (f3)
                  3'd1: o.mnemonic = rvdec_pkg::MN_CSRRW;
                  3'd2: o.mnemonic = rvdec_pkg::MN_CSRRS;
                  3'd3: o.mnemonic = rvdec_pkg::MN_CSRRC;
                  3'd5: o.mnemonic = rvdec_pkg::MN_CSRRWI;
                  3'd6: o.mnemonic = rvdec_pkg::MN_CSRRSI;
                  3'd7: o.mnemonic = rvdec_pkg::MN_CSRRCI;
                  default: ok = 1'b0;
               endcase
            end
         end
         default: ok = 1'b0;
      endcase
      if (!ok) begin
         o = '0;
      end else begin
         o.valid_res = 1'b1;
      end
      return o;
   endfunction

   // mostly well-formed encodings with random content, some broken, some pure noise
   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      logic [6:0]  opc;
      logic        coin;
      int          pick;
      w    = $urandom;
      pick = $urandom_range(0, 99);
      coin = 1'($urandom_range(0, 1));
      if (pick < 10) return w;
      case ($urandom_range(0, 10))
         0: opc = rvdec_pkg::OP_R;
         1: opc = rvdec_pkg::OP_S;
         2: opc = rvdec_pkg::OP_B;
         3: opc = rvdec_pkg::OP_LUI;
         4: opc = rvdec_pkg::OP_AUIPC;
         5: opc = rvdec_pkg::OP_JAL;
         6: opc = rvdec_pkg::OP_JALR;
         7: opc = rvdec_pkg::OP_LOAD;
         8: opc = rvdec_pkg::OP_IALU;
         9: opc = rvdec_pkg::OP_FENCE;
         default: opc = rvdec_pkg::OP_SYS;
      endcase
      w[6:0] = opc;
      if (pick < 25) return w;
      case (opc)
         rvdec_pkg::OP_R: begin
            if ((w[14:12] == 3'd0 || w[14:12] == 3'd5) && coin) begin
               w[31:25] = rvdec_pkg::F7_ALT;
            end else begin
               w[31:25] = rvdec_pkg::F7_BASE;
            end
         end
         rvdec_pkg::OP_LOAD: begin
            while (w[14:12] == 3'd3 || w[14:12] > 3'd5) w[14:12] = 3'($urandom_range(0, 7));
         end
         rvdec_pkg::OP_S: w[14:12] = 3'($urandom_range(0, 2));
         rvdec_pkg::OP_B: begin
            while (w[14:13] == 2'b01) w[14:12] = 3'($urandom_range(0, 7));
         end
         rvdec_pkg::OP_JALR: w[14:12] = 3'd0;
         rvdec_pkg::OP_IALU: begin
            if (w[14:12] == 3'd1) w[31:25] = rvdec_pkg::F7_BASE;
            if (w[14:12] == 3'd5) w[31:25] = coin ? rvdec_pkg::F7_ALT : rvdec_pkg::F7_BASE;
         end
         rvdec_pkg::OP_FENCE: w[14:13] = 2'b00;
         rvdec_pkg::OP_SYS: begin
            while (w[14:12] == 3'd4) w[14:12] = 3'($urandom_range(0, 7));
            if (w[14:12] == 3'd0) w[31:7] = {11'd0, coin, 13'd0};
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic queue_instr(logic [31:0] word, logic [31:0] addr, bit drain);
      instr_entry_type e;
      e.req.instr_word = word;
      e.req.instr_addr = addr;
      e.drain          = drain;
      instr_queue.push_back(e);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_decodes.push_back(decode_rv32i(req_data));
         end
         if (!(start && busy)) begin
            // no gaps over a stretch of the random part
            gap = (issued < 300 || issued >= 450) && ($urandom_range(0, 99) < 18);
            if (instr_queue.size() > 0 && !gap &&
                !(instr_queue[0].drain && expected_decodes.size() != 0)) begin
               issue_entry = instr_queue.pop_front();
               req_data   <= issue_entry.req;
               start      <= 1'b1;
               issued++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_decodes.size() == 0) begin
            if (decode_mismatches < 10) begin
               $display("unexpected item on rsp_data: %h", rsp_data);
            end
            decode_mismatches++;
         end else begin
            want_rsp = expected_decodes.pop_front();
            if (rsp_data.valid_res !== want_rsp.valid_res ||
                rsp_data.format    !== want_rsp.format    ||
                rsp_data.mnemonic  !== want_rsp.mnemonic  ||
                rsp_data.dest_reg  !== want_rsp.dest_reg  ||
                rsp_data.src1_reg  !== want_rsp.src1_reg  ||
                rsp_data.src2_reg  !== want_rsp.src2_reg  ||
                rsp_data.immediate !== want_rsp.immediate ||
                rsp_data.target    !== want_rsp.target) begin
               if (decode_mismatches < 10) begin
                  $display("mismatch exp: v=%0d fmt=%0d mn=%0d rd=%0d rs1=%0d rs2=%0d imm=%h tgt=%h",
                           want_rsp.valid_res, want_rsp.format, want_rsp.mnemonic,
                           want_rsp.dest_reg, want_rsp.src1_reg, want_rsp.src2_reg,
                           want_rsp.immediate, want_rsp.target);
                  $display("         got: v=%0d fmt=%0d mn=%0d rd=%0d rs1=%0d rs2=%0d imm=%h tgt=%h",
                           rsp_data.valid_res, rsp_data.format, rsp_data.mnemonic,
                           rsp_data.dest_reg, rsp_data.src1_reg, rsp_data.src2_reg,
                           rsp_data.immediate, rsp_data.target);
               end
               decode_mismatches++;
            end
         end
      end
   end

   initial begin
      queue_instr(32'h0000_0000, 32'h0000_0000, 1'b0);
      queue_instr(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_instr({rvdec_pkg::F7_ALT, 5'd31, 5'd31, 3'd0, 5'd31, rvdec_pkg::OP_R},
                  32'h0000_1000, 1'b0);
      queue_instr({rvdec_pkg::F7_ALT, 5'd1, 5'd2, 3'd5, 5'd3, rvdec_pkg::OP_R},
                  32'h0000_1004, 1'b0);
      queue_instr({rvdec_pkg::F7_ALT, 5'd1, 5'd2, 3'd1, 5'd3, rvdec_pkg::OP_R},
                  32'h0000_1008, 1'b0);
      queue_instr({7'h01, 5'd4, 5'd5, 3'd0, 5'd6, rvdec_pkg::OP_R}, 32'h0000_100C, 1'b0);
      queue_instr({12'h800, 5'd1, 3'd2, 5'd5, rvdec_pkg::OP_LOAD}, 32'h0000_1010, 1'b0);
      queue_instr({12'h7FF, 5'd1, 3'd3, 5'd5, rvdec_pkg::OP_LOAD}, 32'h0000_1014, 1'b0);
      queue_instr({7'h40, 5'd2, 5'd3, 3'd2, 5'd0, rvdec_pkg::OP_S}, 32'h0000_1018, 1'b0);
      queue_instr({7'h3F, 5'd2, 5'd3, 3'd3, 5'd31, rvdec_pkg::OP_S}, 32'h0000_101C, 1'b0);
      queue_instr({1'b0, 6'h3F, 5'd2, 5'd1, 3'd4, 4'hF, 1'b1, rvdec_pkg::OP_B},
                  32'hFFFF_FFF0, 1'b0);
      queue_instr({1'b1, 6'h00, 5'd2, 5'd1, 3'd5, 4'h0, 1'b0, rvdec_pkg::OP_B},
                  32'h0000_0000, 1'b0);
      queue_instr({1'b0, 6'h01, 5'd2, 5'd1, 3'd2, 4'h2, 1'b0, rvdec_pkg::OP_B},
                  32'h0000_2000, 1'b0);
      queue_instr({20'h80000, 5'd1, rvdec_pkg::OP_LUI}, 32'h0000_2004, 1'b0);
      queue_instr({20'hFFFFF, 5'd31, rvdec_pkg::OP_AUIPC}, 32'h0000_2008, 1'b0);
      queue_instr({1'b1, 10'd0, 1'b0, 8'd0, 5'd1, rvdec_pkg::OP_JAL}, 32'h0000_0000, 1'b0);
      queue_instr({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, rvdec_pkg::OP_JAL},
                  32'hFFFF_FFFF, 1'b0);
      queue_instr({12'h123, 5'd1, 3'd1, 5'd1, rvdec_pkg::OP_JALR}, 32'h0000_200C, 1'b0);
      queue_instr({rvdec_pkg::F7_ALT, 5'd31, 5'd1, 3'd1, 5'd1, rvdec_pkg::OP_IALU},
                  32'h0000_2010, 1'b0);
      queue_instr({rvdec_pkg::F7_ALT, 5'd31, 5'd1, 3'd5, 5'd1, rvdec_pkg::OP_IALU},
                  32'h0000_2014, 1'b0);
      queue_instr({7'h01, 5'd7, 5'd1, 3'd5, 5'd1, rvdec_pkg::OP_IALU}, 32'h0000_2018, 1'b0);
      queue_instr({4'hF, 4'hF, 4'hF, 5'd1, 3'd0, 5'd1, rvdec_pkg::OP_FENCE},
                  32'h0000_201C, 1'b0);
      queue_instr({12'h0FF, 5'd1, 3'd2, 5'd1, rvdec_pkg::OP_FENCE}, 32'h0000_2020, 1'b0);
      queue_instr({12'd0, 5'd0, 3'd0, 5'd0, rvdec_pkg::OP_SYS}, 32'h0000_2024, 1'b0);
      queue_instr({12'd1, 5'd0, 3'd0, 5'd0, rvdec_pkg::OP_SYS}, 32'h0000_2028, 1'b0);
      queue_instr({12'd0, 5'd0, 3'd0, 5'd1, rvdec_pkg::OP_SYS}, 32'h0000_202C, 1'b0);
      queue_instr({12'h305, 5'd3, 3'd4, 5'd2, rvdec_pkg::OP_SYS}, 32'h0000_2030, 1'b0);
      queue_instr({12'hFFF, 5'd31, 3'd7, 5'd31, rvdec_pkg::OP_SYS}, 32'h0000_2034, 1'b0);
      for (int i = 0; i < 900; i++) begin
         queue_instr(random_instr(), $urandom, i == 0 || i == 450);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (instr_queue.size() > 0 || start || expected_decodes.size() > 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (decode_mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* rv32i_instruction_decoder.f */
rtl/rvdec_pkg.sv
rtl/rv32i_instruction_decoder.sv
verif/rv32i_instruction_decoder_tb.sv
